/* sv/drc_pkg.sv */
package drc_pkg;

  // Default number of cache entries, and the entry count after reset.
  localparam int DEFAULT_DEPTH = 64;
  localparam int ENTRIES_RESET = 64;

  // Fixed field widths of the stream and configuration ports.
  localparam int SLOT_OUT_W  = 6;
  localparam int LEN_W       = 16;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES = 2'd1;

  // Operation codes carried in the input tuser.
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Full call key; peer holds the port in the upper 16 bits.
  typedef struct packed {
    logic [47:0] peer;
    logic [31:0] proc;
    logic [31:0] vers;
    logic [31:0] prog;
    logic [31:0] xid;
  } drc_key_t;

  typedef struct packed {
    drc_key_t         key;
    logic [LEN_W-1:0] len;
  } drc_entry_t;

  // Partial search result handed from cell to cell.
  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len;
  } drc_res_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic shift;
    logic start;
    logic step;
  } drc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } drc_state_t;

endpackage

/* sv/drc_cell.sv */
module drc_cell import drc_pkg::*; #(
  parameter int POS = 0,
  parameter int CW  = 7,
  parameter int SW  = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  drc_ctrl_t        ctrl,
  input  logic [CW-1:0]    used_n,
  input  drc_key_t         key,
  input  logic             valid_in,
  input  drc_entry_t       ent_in,
  input  logic [SW-1:0]    slot_in,
  output logic             valid_out,
  output drc_entry_t       ent_out,
  output logic [SW-1:0]    slot_out,
  input  drc_res_t         res_in,
  input  logic [SW-1:0]    res_slot_in,
  output drc_res_t         res_out,
  output logic [SW-1:0]    res_slot_out
);

  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic             valid;
  drc_entry_t       ent;
  logic [SW-1:0]    slot;
  logic             res_hit;
  logic [LEN_W-1:0] res_len;
  logic [SW-1:0]    res_slot;
  logic             match;

  // Entries at or beyond the count in use have been overwritten in slot terms.
  assign match = valid && (POS_C < used_n) && (ent.key == key);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      ent  <= ent_in;
      slot <= slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      res_hit <= 1'b0;
    end else if (ctrl.step) begin
      res_hit <= match || res_in.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (match) begin
        res_len  <= ent.len;
        res_slot <= slot;
      end else begin
        res_len  <= res_in.len;
        res_slot <= res_slot_in;
      end
    end
  end

  assign valid_out    = valid;
  assign ent_out      = ent;
  assign slot_out     = slot;
  assign res_out      = '{hit: res_hit, len: res_len};
  assign res_slot_out = res_slot;

endmodule

/* sv/rpc_duplicate_request_cache_core.sv */
// Channel  Signals                                   Direction  Carries
// -------  ----------------------------------------  ---------  -------------------------------
// s        s_tvalid s_tready s_tdata s_tuser         in         one lookup or insert item
// m        m_tvalid m_tready m_tdata                 out        one result item per input item
// cfg      cfg_valid cfg_ready cfg_index cfg_data    in         register writes
//
// An insert, or a lookup while the cache is disabled, produces its result in the cycle after it
// is accepted. An enabled lookup passes the search and finish states before its result is
// registered, and the next item waits for the idle state: the search result travels one cell
// per cycle along the chain of entry cells toward cell zero.
// Reset is synchronous and leaves the cache empty at once; no clearing pass is needed.
// A result waiting in the output register blocks the next item until m_tready takes it.
module rpc_duplicate_request_cache_core import drc_pkg::*; #(
  parameter int CACHE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // xid[31:0], prog[63:32], vers[95:64], proc[127:96], peer_addr[159:128],
  // peer_port[175:160], reply_len[191:176]
  input  logic [191:0]           s_tdata,
  // func[0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // hit[0], slot[6:1], cached_len[22:7], stored[23]
  output logic [23:0]            m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Count width holds the depth itself; slot width indexes the cells.
  localparam int CW      = $clog2(CACHE_DEPTH + 1);
  localparam int SW      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int EW      = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int RESET_N = (CACHE_DEPTH < ENTRIES_RESET) ? CACHE_DEPTH : ENTRIES_RESET;

  drc_state_t       state;
  drc_state_t       state_next;
  drc_ctrl_t        cell_ctrl;

  logic             enable;
  logic [CW-1:0]    used_n;
  logic [CW-1:0]    used_n_next;
  logic [SW-1:0]    vp;
  logic [CW-1:0]    vp_inc;
  logic [CW-1:0]    count;

  logic [31:0]      pending_xid;
  logic [31:0]      pending_prog;
  logic [31:0]      pending_vers;
  logic [31:0]      pending_proc;
  logic [47:0]      pending_peer;
  drc_key_t         search_key;

  logic             out_valid;
  logic             out_hit;
  logic [SW-1:0]    out_slot;
  logic [LEN_W-1:0] out_len;
  logic             out_stored;

  logic             s_acc;
  logic             cfg_acc;
  logic             is_insert;
  logic             direct_result;
  logic             empty;
  logic [EW-1:0]    cfg_wide;
  drc_key_t         in_key;

  logic             valid_c    [0:CACHE_DEPTH];
  drc_entry_t       ent_c      [0:CACHE_DEPTH];
  logic [SW-1:0]    slot_c     [0:CACHE_DEPTH];
  drc_res_t         res_c      [0:CACHE_DEPTH];
  logic [SW-1:0]    res_slot_c [0:CACHE_DEPTH];

  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign is_insert = (s_tuser == FUNC_INSERT);

  assign in_key = '{peer: s_tdata[175:128], proc: s_tdata[127:96], vers: s_tdata[95:64],
                    prog: s_tdata[63:32], xid: s_tdata[31:0]};

  // Resizing always empties the cache; enabling empties it only on a rising change.
  assign empty = cfg_acc && (((cfg_index == CFG_ENABLE) && cfg_data[0] && !enable) ||
                             (cfg_index == CFG_ENTRIES));

  // Entry count in use: zero acts as one, anything above the depth acts as the depth.
  assign cfg_wide = EW'(cfg_data);
  always_comb begin
    if (cfg_wide == '0) begin
      used_n_next = CW'(1);
    end else if (cfg_wide > EW'(CACHE_DEPTH)) begin
      used_n_next = CW'(CACHE_DEPTH);
    end else begin
      used_n_next = CW'(cfg_wide);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc && !is_insert && enable) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (count == CW'(1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake and cell controls.
  always_comb begin
    s_tready        = (state == ST_IDLE) && (!out_valid || m_tready);
    cell_ctrl.clear = empty;
    cell_ctrl.shift = s_acc && is_insert && enable;
    cell_ctrl.start = s_acc && !is_insert && enable;
    cell_ctrl.step  = (state == ST_SEARCH);
    direct_result   = s_acc && (is_insert || !enable);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      used_n <= CW'(RESET_N);
    end else if (cfg_acc) begin
      if (cfg_index == CFG_ENABLE) begin
        enable <= cfg_data[0];
      end else if (cfg_index == CFG_ENTRIES) begin
        used_n <= used_n_next;
      end
    end
  end

  // The victim pointer always stays below the entry count in use.
  assign vp_inc = CW'(vp) + CW'(1);
  always_ff @(posedge clk) begin
    if (rst || empty) begin
      vp <= '0;
    end else if (cell_ctrl.shift) begin
      if (vp_inc >= used_n) begin
        vp <= '0;
      end else begin
        vp <= SW'(vp_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cell_ctrl.start) begin
      count <= used_n;
    end else if (state == ST_SEARCH) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ctrl.start) begin
      search_key <= in_key;
    end
  end

  // A lookup always records its transaction id; a miss also records the rest of the key.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_xid  <= '0;
      pending_prog <= '0;
      pending_vers <= '0;
      pending_proc <= '0;
      pending_peer <= '0;
    end else begin
      if (s_acc && !is_insert) begin
        pending_xid <= in_key.xid;
      end
      if ((state == ST_FINISH) && !res_c[0].hit) begin
        pending_prog <= search_key.prog;
        pending_vers <= search_key.vers;
        pending_proc <= search_key.proc;
        pending_peer <= search_key.peer;
      end
    end
  end

  // Cell zero receives the new entry; the search wave enters from the far end.
  assign valid_c[0] = 1'b1;
  assign ent_c[0]   = '{key: '{peer: pending_peer, proc: pending_proc, vers: pending_vers,
                               prog: pending_prog, xid: pending_xid},
                        len: s_tdata[191:176]};
  assign slot_c[0]  = vp;
  assign res_c[CACHE_DEPTH]      = '0;
  assign res_slot_c[CACHE_DEPTH] = '0;

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    drc_cell #(
      .POS (k),
      .CW  (CW),
      .SW  (SW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .used_n       (used_n),
      .key          (search_key),
      .valid_in     (valid_c[k]),
      .ent_in       (ent_c[k]),
      .slot_in      (slot_c[k]),
      .valid_out    (valid_c[k+1]),
      .ent_out      (ent_c[k+1]),
      .slot_out     (slot_c[k+1]),
      .res_in       (res_c[k+1]),
      .res_slot_in  (res_slot_c[k+1]),
      .res_out      (res_c[k]),
      .res_slot_out (res_slot_c[k])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (direct_result || (state == ST_FINISH)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_result) begin
      out_hit    <= 1'b0;
      out_slot   <= cell_ctrl.shift ? vp : '0;
      out_len    <= '0;
      out_stored <= cell_ctrl.shift;
    end else if (state == ST_FINISH) begin
      out_hit    <= res_c[0].hit;
      out_slot   <= res_c[0].hit ? res_slot_c[0] : '0;
      out_len    <= res_c[0].hit ? res_c[0].len : '0;
      out_stored <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_stored, out_len, SLOT_OUT_W'(out_slot), out_hit};

  // The output register is free for the whole of a search.
  a_out_free_in_search: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result pending while a search is running");

  // The victim pointer never reaches the entry count in use.
  a_vp_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(vp) < used_n)
    else $error("victim pointer out of range");

  // An insert shift never overlaps a search step.
  a_no_shift_in_search: assert property (@(posedge clk) disable iff (rst)
    !(cell_ctrl.shift && cell_ctrl.step))
    else $error("chain shifted during a search");

  // A search always has cycles left while running.
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (count != '0))
    else $error("search counter expired while searching");

  // The finish cycle follows the last search step.
  a_finish_follows: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SEARCH) && (count == CW'(1))) |=> (state == ST_FINISH))
    else $error("search did not finish");

endmodule
